// ===== hdl/spr_pkg.sv =====
// ============================================================================
// spr_pkg - shared types and constants for the stream pattern replacer
// Register map, job descriptor passed from the front to the back, and the
// length clamping helpers.
// ============================================================================
package spr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 4;
    localparam int WORD_W          = 64;
    localparam int DATA_W          = 64;
    localparam int ADDR_W          = 5;
    localparam int SLOT_W          = 3;

    typedef enum logic [1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } reg_index_t;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic [WORD_W-1:0] pattern_bytes;
        logic [LEN_W-1:0]  pattern_length;
        logic [WORD_W-1:0] replacement_bytes;
        logic [LEN_W-1:0]  replacement_length;
    } cfg_t;

    // Bytes to emit for one accepted input transfer, byte 0 first.
    typedef struct packed {
        logic [WORD_W-1:0] bytes;
        logic [LEN_W-1:0]  count;
        logic              last;
    } job_t;

    function automatic logic [LEN_W-1:0] eff_pattern_len(input logic [LEN_W-1:0] n);
        logic [LEN_W-1:0] r;
        r = n;
        if (n == '0)
        begin
            r = LEN_W'(1);
        end
        else if (n > LEN_W'(MAX_PATTERN))
        begin
            r = LEN_W'(MAX_PATTERN);
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] eff_replacement_len(input logic [LEN_W-1:0] n);
        logic [LEN_W-1:0] r;
        r = n;
        if (n > LEN_W'(MAX_REPLACEMENT))
        begin
            r = LEN_W'(MAX_REPLACEMENT);
        end
        return r;
    endfunction

endpackage

// ===== hdl/spr_front.sv =====
// ============================================================================
// spr_front - window and compare stage
// Inserts each accepted byte into the pending window, compares against the
// pattern and builds the job of bytes the transfer releases.
// ============================================================================
module spr_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  spr_pkg::cfg_t              cfg,
    input  logic                       window_clear,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [spr_pkg::BYTE_W-1:0] in_byte,
    input  logic                       end_of_text,
    input  logic                       queue_full,
    output logic                       push,
    output spr_pkg::job_t              job
);

    spr_pkg::byte_t                  window_reg  [spr_pkg::MAX_PATTERN];
    spr_pkg::byte_t                  window_next [spr_pkg::MAX_PATTERN];
    spr_pkg::byte_t                  win_ins     [spr_pkg::MAX_PATTERN];
    logic [spr_pkg::LEN_W-1:0]       fill_reg;
    logic [spr_pkg::LEN_W-1:0]       fill_next;
    logic [spr_pkg::LEN_W-1:0]       plen;
    logic [spr_pkg::LEN_W-1:0]       fill0;
    logic [spr_pkg::LEN_W-1:0]       nf;
    logic [spr_pkg::WORD_W-1:0]      win_word;
    logic                            full;
    logic                            mismatch;
    logic                            is_match;
    logic                            accept;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    always_comb
    begin
        plen  = spr_pkg::eff_pattern_len(cfg.pattern_length);
        fill0 = (fill_reg >= plen) ? '0 : fill_reg;
        nf    = fill0 + spr_pkg::LEN_W'(1);
        full  = (nf == plen);

        mismatch = 1'b0;
        for (int k = 0; k < spr_pkg::MAX_PATTERN; k++)
        begin
            win_ins[k] = (spr_pkg::LEN_W'(k) == fill0) ? in_byte : window_reg[k];
            win_word[k*spr_pkg::BYTE_W +: spr_pkg::BYTE_W] = win_ins[k];
            if ((spr_pkg::LEN_W'(k) < plen)
                && (win_ins[k] != cfg.pattern_bytes[k*spr_pkg::BYTE_W +: spr_pkg::BYTE_W]))
            begin
                mismatch = 1'b1;
            end
        end
        is_match = full && !mismatch;

        window_next = win_ins;
        job.last    = end_of_text;
        job.bytes   = win_word;
        if (is_match)
        begin
            job.bytes = cfg.replacement_bytes;
            job.count = spr_pkg::eff_replacement_len(cfg.replacement_length);
            fill_next = '0;
        end
        else if (end_of_text)
        begin
            // flush everything pending, oldest first
            job.count = nf;
            fill_next = '0;
        end
        else if (full)
        begin
            // release the oldest byte and shift the window down
            job.count = spr_pkg::LEN_W'(1);
            fill_next = nf - spr_pkg::LEN_W'(1);
            for (int k = 0; k < spr_pkg::MAX_PATTERN - 1; k++)
            begin
                window_next[k] = win_ins[k+1];
            end
        end
        else
        begin
            job.count = '0;
            fill_next = nf;
        end
    end

    // Drop empty jobs here; only the end mark needs a slot when nothing is emitted.
    assign push = accept && ((job.count != '0) || job.last);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_reg <= window_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (window_clear)
        begin
            fill_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== hdl/spr_queue.sv =====
// ============================================================================
// spr_queue - job queue
// Small FIFO of job descriptors between the front and the back.
// ============================================================================
module spr_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  spr_pkg::job_t push_data,
    input  logic          pop,
    output spr_pkg::job_t head,
    output logic          empty,
    output logic          full
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    spr_pkg::job_t    slot_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + IDX_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + IDX_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== hdl/spr_back.sv =====
// ============================================================================
// spr_back - emission sequencer
// Steps through the bytes of the head job, one result per cycle while out_stall
// is low, into the output register.
// ============================================================================
module spr_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  spr_pkg::job_t              head,
    input  logic                       queue_empty,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [spr_pkg::BYTE_W-1:0] out_byte,
    output logic                       byte_present,
    output logic                       end_of_output
);

    logic [spr_pkg::SLOT_W-1:0] idx_reg;
    logic                       out_valid_reg;
    logic [spr_pkg::BYTE_W-1:0] out_byte_reg;
    logic                       present_reg;
    logic                       end_reg;
    logic                       can_load;
    logic                       load;
    logic                       final_byte;
    logic                       end_only;

    assign can_load   = !out_valid_reg || !out_stall;
    assign load       = can_load && !queue_empty;
    assign end_only   = (head.count == '0);
    assign final_byte = ({1'b0, idx_reg} == head.count - spr_pkg::LEN_W'(1));
    assign pop        = load && (end_only || final_byte);

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_present  = present_reg;
    assign end_of_output = end_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (end_only)
            begin
                out_byte_reg <= '0;
                present_reg  <= 1'b0;
                end_reg      <= 1'b1;
            end
            else
            begin
                out_byte_reg <= head.bytes[idx_reg*spr_pkg::BYTE_W +: spr_pkg::BYTE_W];
                present_reg  <= 1'b1;
                end_reg      <= head.last && final_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= pop ? '0 : idx_reg + spr_pkg::SLOT_W'(1);
            end
            else if (can_load)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/stream_pattern_replace_top.sv =====
// ============================================================================
// stream_pattern_replace_top - streaming find-and-replace on a byte stream
// Replaces each leftmost non-overlapping occurrence of a 1..8 byte pattern
// with a 0..8 byte replacement, flushing pending bytes at end of text.
// ============================================================================
//
//  Channel  Direction  Handshake              Payload
//  -------  ---------  ---------------------  -----------------------------------
//  in       sink       in_valid / in_stall    in_byte, end_of_text
//  out      source     out_valid / out_stall  out_byte, byte_present, end_of_output
//  cfg      APB slave  psel/penable/pready    paddr, pwdata, prdata (64 bit)
//
//  The front takes one byte per cycle while the job queue is not full; the back
//  gives one result per cycle while out_stall is low. A transfer that releases n
//  bytes (a replacement, or a flush at end of text) holds the back until all are
//  given; input stalls only once the job queue of QUEUE_DEPTH entries is full. A
//  result follows its input through the job queue and the output register. Reset
//  is asynchronous and takes effect at once; there is no clearing pass. The output
//  register holds its result while out_stall is high.
module stream_pattern_replace_top
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spr_pkg::ADDR_W-1:0]  paddr,
    input  logic [spr_pkg::DATA_W-1:0]  pwdata,
    output logic [spr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // input stream
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [spr_pkg::BYTE_W-1:0]  in_byte,
    input  logic                        end_of_text,
    // output stream
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [spr_pkg::BYTE_W-1:0]  out_byte,
    output logic                        byte_present,
    output logic                        end_of_output
);

    spr_pkg::cfg_t       cfg_reg;
    spr_pkg::reg_index_t reg_sel;
    spr_pkg::job_t       push_job;
    spr_pkg::job_t       head_job;
    logic                cfg_write;
    logic                window_clear;
    logic                push;
    logic                pop;
    logic                queue_empty;
    logic                queue_full;

    // Registers sit on 8-byte boundaries; the low address bits are ignored.
    assign reg_sel   = spr_pkg::reg_index_t'(paddr[spr_pkg::ADDR_W-1:3]);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // A new pattern length invalidates whatever is pending in the window.
    assign window_clear = cfg_write && (reg_sel == spr_pkg::REG_PATTERN_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_bytes      <= '0;
            cfg_reg.pattern_length     <= spr_pkg::LEN_W'(1);
            cfg_reg.replacement_bytes  <= '0;
            cfg_reg.replacement_length <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                spr_pkg::REG_PATTERN_BYTES:
                begin
                    cfg_reg.pattern_bytes <= pwdata;
                end
                spr_pkg::REG_PATTERN_LENGTH:
                begin
                    cfg_reg.pattern_length <= pwdata[spr_pkg::LEN_W-1:0];
                end
                spr_pkg::REG_REPLACEMENT_BYTES:
                begin
                    cfg_reg.replacement_bytes <= pwdata;
                end
                spr_pkg::REG_REPLACEMENT_LENGTH:
                begin
                    cfg_reg.replacement_length <= pwdata[spr_pkg::LEN_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // Read back the stored register values.
    always_comb
    begin
        case (reg_sel)
            spr_pkg::REG_PATTERN_BYTES:
            begin
                prdata = cfg_reg.pattern_bytes;
            end
            spr_pkg::REG_PATTERN_LENGTH:
            begin
                prdata = spr_pkg::DATA_W'(cfg_reg.pattern_length);
            end
            spr_pkg::REG_REPLACEMENT_BYTES:
            begin
                prdata = cfg_reg.replacement_bytes;
            end
            spr_pkg::REG_REPLACEMENT_LENGTH:
            begin
                prdata = spr_pkg::DATA_W'(cfg_reg.replacement_length);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // Front: accept each input transfer, update the window, build a job.
    spr_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .window_clear (window_clear),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .end_of_text  (end_of_text),
        .queue_full   (queue_full),
        .push         (push),
        .job          (push_job)
    );

    // Queue: decouple the front from the back so each can stall on its own.
    spr_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .head      (head_job),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    // Back: emit the bytes of each job, one output transfer per cycle while out_stall is low.
    spr_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head_job),
        .queue_empty   (queue_empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .byte_present  (byte_present),
        .end_of_output (end_of_output)
    );

endmodule

// ===== bench/stream_pattern_replace_checker.sv =====
// ============================================================================
// stream_pattern_replace_checker - result predictor and scoreboard
// Watches the configuration port and both stream channels, rewrites each
// accepted input byte into the results it must release, and compares every
// output transfer field by field with the oldest outstanding expectation.
// ============================================================================
module stream_pattern_replace_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spr_pkg::ADDR_W-1:0]          paddr,
    input  logic [spr_pkg::DATA_W-1:0]          pwdata,
    input  logic                                pready,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [spr_pkg::BYTE_W-1:0]          in_byte,
    input  logic                                end_of_text,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [spr_pkg::BYTE_W-1:0]          out_byte,
    input  logic                                byte_present,
    input  logic                                end_of_output,
    output int                                  mismatches,
    output int                                  pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import spr_pkg::*;

    localparam int PRINT_CAP = 200;

    typedef struct {
        byte_t data;
        logic  present;
        logic  last;
    } text_result_t;

    logic [WORD_W-1:0] pattern_word        = '0;
    logic [LEN_W-1:0]  pattern_len_reg     = LEN_W'(1);
    logic [WORD_W-1:0] replacement_word    = '0;
    logic [LEN_W-1:0]  replacement_len_reg = '0;
    byte_t             window_q [MAX_PATTERN];
    int unsigned       window_fill         = 0;
    text_result_t      expected_q [$];
    int                printed             = 0;

    initial
    begin
        mismatches      = 0;
        pending_results = 0;
    end

    function automatic int unsigned pattern_span();
        int unsigned n;
        n = pattern_len_reg;
        if (n == 0)
        begin
            n = 1;
        end
        else if (n > MAX_PATTERN)
        begin
            n = MAX_PATTERN;
        end
        return n;
    endfunction

    function automatic int unsigned replacement_span();
        int unsigned n;
        n = replacement_len_reg;
        if (n > MAX_REPLACEMENT)
        begin
            n = MAX_REPLACEMENT;
        end
        return n;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (printed < PRINT_CAP)
        begin
            $display("%0t ns: mismatch: %s", $time, what);
            printed++;
        end
    endtask

    task automatic take_register_write(input logic [ADDR_W-1:0] addr,
                                       input logic [DATA_W-1:0] value);
        case (reg_index_t'(addr >> 3))
            REG_PATTERN_BYTES:      pattern_word = value;
            REG_PATTERN_LENGTH:
            begin
                // a new pattern length drops whatever the window holds
                pattern_len_reg = value[LEN_W-1:0];
                window_fill     = 0;
            end
            REG_REPLACEMENT_BYTES:  replacement_word = value;
            REG_REPLACEMENT_LENGTH: replacement_len_reg = value[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic rewrite_byte(input byte_t b, input logic eot);
        int unsigned  plen;
        int unsigned  rlen;
        int unsigned  k;
        logic         hit;
        text_result_t r;
        text_result_t step_q [$];
        plen = pattern_span();
        rlen = replacement_span();
        if (window_fill >= plen)
        begin
            window_fill = 0;
        end
        window_q[window_fill] = b;
        window_fill++;
        if (window_fill == plen)
        begin
            hit = 1'b1;
            for (k = 0; k < plen; k++)
            begin
                if (window_q[k] != pattern_word[8*k +: 8])
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                for (k = 0; k < rlen; k++)
                begin
                    r.data    = replacement_word[8*k +: 8];
                    r.present = 1'b1;
                    r.last    = 1'b0;
                    step_q.push_back(r);
                end
                window_fill = 0;
            end
            else
            begin
                r.data    = window_q[0];
                r.present = 1'b1;
                r.last    = 1'b0;
                step_q.push_back(r);
                for (k = 1; k < window_fill; k++)
                begin
                    window_q[k-1] = window_q[k];
                end
                window_fill--;
            end
        end
        if (eot)
        begin
            for (k = 0; k < window_fill; k++)
            begin
                r.data    = window_q[k];
                r.present = 1'b1;
                r.last    = 1'b0;
                step_q.push_back(r);
            end
            window_fill = 0;
            if (step_q.size() == 0)
            begin
                r.data    = '0;
                r.present = 1'b0;
                r.last    = 1'b0;
                step_q.push_back(r);
            end
            r      = step_q.pop_back();
            r.last = 1'b1;
            step_q.push_back(r);
        end
        foreach (step_q[i])
        begin
            expected_q.push_back(step_q[i]);
        end
    endtask

    task automatic check_result();
        text_result_t want;
        if (expected_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result byte %02h present %0b end %0b",
                                      out_byte, byte_present, end_of_output));
        end
        else
        begin
            want = expected_q.pop_front();
            if (out_byte !== want.data)
            begin
                report_mismatch($sformatf("out_byte %02h, expected %02h",
                                          out_byte, want.data));
            end
            if (byte_present !== want.present)
            begin
                report_mismatch($sformatf("byte_present %0b, expected %0b",
                                          byte_present, want.present));
            end
            if (end_of_output !== want.last)
            begin
                report_mismatch($sformatf("end_of_output %0b, expected %0b",
                                          end_of_output, want.last));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_word        = '0;
            pattern_len_reg     = LEN_W'(1);
            replacement_word    = '0;
            replacement_len_reg = '0;
            window_fill         = 0;
            expected_q.delete();
            pending_results     = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                take_register_write(paddr, pwdata);
            end
            if (in_valid && !in_stall)
            begin
                rewrite_byte(in_byte, end_of_text);
            end
            if (out_valid && !out_stall)
            begin
                check_result();
            end
            pending_results = expected_q.size();
        end
    end

endmodule

// ===== bench/stream_pattern_replace_top_tb.sv =====
// ============================================================================
// stream_pattern_replace_top_tb - testbench for the stream pattern replacer
// Drives byte texts through the replacer under several register settings and
// idling mixes, leaves prediction and comparison to the checker beside the
// block, and gives the verdict once every expected result has arrived.
// ============================================================================
module stream_pattern_replace_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spr_pkg::*;

    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 43;
    localparam int SETTLE_CYCLES   = 12;   // settle time after the last expected result
    localparam int HOLD_OFF        = 300;  // long receiver hold-off, in cycles
    localparam int WATCHDOG_LIMIT  = 2000; // cycles without any transfer

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // block inputs, all known from time zero
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [DATA_W-1:0]   pwdata      = '0;
    logic                in_valid    = 1'b0;
    byte_t               in_byte     = '0;
    logic                end_of_text = 1'b0;
    logic                out_stall   = 1'b0;

    // block outputs
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_stall;
    logic                out_valid;
    byte_t               out_byte;
    logic                byte_present;
    logic                end_of_output;

    // checker feedback
    int                  mismatch_count;
    int                  results_due;

    // stimulus state
    idle_mode_t          idle_mode    = IDLE_NONE;
    int                  hold_left    = 0;
    int                  items_sent   = 0;
    int                  quiet_cycles = 0;
    logic [WORD_W-1:0]   stim_pattern = '0;
    int unsigned         stim_plen    = 1;

    always #1 clk = ~clk;

    stream_pattern_replace_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .byte_present  (byte_present),
        .end_of_output (end_of_output)
    );

    stream_pattern_replace_checker text_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_byte         (in_byte),
        .end_of_text     (end_of_text),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .byte_present    (byte_present),
        .end_of_output   (end_of_output),
        .mismatches      (mismatch_count),
        .pending_results (results_due)
    );

    // Receiver: decide the stall for the coming cycle at each falling edge.
    // A pending hold-off wins over the random mix and is counted down here.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            case (idle_mode)
                IDLE_RECEIVER: out_stall <= ($urandom_range(99) < 69);
                IDLE_BOTH:     out_stall <= ($urandom_range(99) < 22);
                default:       out_stall <= 1'b0;
            endcase
        end
    end

    // Watchdog: count cycles with no transfer on any port; end the run if the
    // block goes quiet for far longer than any correct run could.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (psel && penable && pready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("[stream_pattern_replace_top] ERROR");
                $finish;
            end
        end
    end

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SENDER: return ($urandom_range(99) < 69);
            IDLE_BOTH:   return ($urandom_range(99) < 22);
            default:     return 1'b0;
        endcase
    endfunction

    // Offer one byte and hold it until the transfer happens. Enter and leave
    // just after a falling edge; valid is only touched once per edge.
    task automatic send_byte(input byte_t b, input logic eot);
        while (sender_idles())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= b;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        @(negedge clk);
    endtask

    // Two-phase register write: setup cycle, then access until pready.
    task automatic cfg_write(input reg_index_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid, wait for every expected result, then let the block settle
    // in case the last transfers are still working their way through.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (results_due != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Build one text around the current pattern: whole copies, cut-off
    // prefixes, loose pattern bytes and plain noise, ended on its last byte.
    task automatic send_text(input int unsigned n_bytes);
        byte_t       text_q [$];
        int unsigned pick;
        int unsigned m;
        int unsigned k;
        while (text_q.size() < n_bytes)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                m = ($urandom_range(3) == 0) ? $urandom_range(1, stim_plen) : stim_plen;
                for (k = 0; k < m; k++)
                begin
                    text_q.push_back(stim_pattern[8*k +: 8]);
                end
            end
            else if (pick < 75)
            begin
                k = $urandom_range(stim_plen - 1);
                text_q.push_back(stim_pattern[8*k +: 8]);
            end
            else
            begin
                text_q.push_back(byte_t'($urandom));
            end
        end
        foreach (text_q[i])
        begin
            send_byte(text_q[i], i == text_q.size() - 1);
        end
    endtask

    initial
    begin
        int                plen_set [N_PHASES];
        int                rlen_set [N_PHASES];
        int                goal;
        byte_t             fill_byte;
        logic [WORD_W-1:0] word;

        plen_set = '{1, 8, 2, 3, 5, 8, 0, 12};
        rlen_set = '{0, 8, 1, 15, 3, 0, 8, 2};

        // hold reset, then release it on a falling edge
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed part, no idling ---
        // reset settings: one-byte pattern 00, empty replacement
        send_byte(8'h00, 1'b0);            // deleted
        send_byte(8'hFF, 1'b1);            // passed through, ends the text
        send_byte(8'h00, 1'b1);            // deleted final byte: end-only marker
        // drop valid and drain before touching the registers
        wait_idle();

        cfg_write(REG_PATTERN_BYTES, 64'h0000_0000_0043_4241);
        cfg_write(REG_PATTERN_LENGTH, 64'd3);
        cfg_write(REG_REPLACEMENT_BYTES, 64'h3837_3635_3433_3231);
        cfg_write(REG_REPLACEMENT_LENGTH, 64'd8);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h43, 1'b0);            // full-length replacement
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);            // partial match flushed at the end
        wait_idle();

        // longest pattern, deleted entirely: end-only marker again
        cfg_write(REG_PATTERN_BYTES, {64{1'b1}});
        cfg_write(REG_PATTERN_LENGTH, 64'd8);
        cfg_write(REG_REPLACEMENT_LENGTH, 64'd0);
        for (int i = 0; i < 8; i++)
        begin
            send_byte(8'hFF, i == 7);
        end
        wait_idle();

        // zero pattern length acts as one; oversized replacement length clamps
        cfg_write(REG_PATTERN_BYTES, 64'h0807_0605_0403_0280);
        cfg_write(REG_PATTERN_LENGTH, 64'd0);
        cfg_write(REG_REPLACEMENT_LENGTH, 64'd15);
        send_byte(8'h80, 1'b1);
        wait_idle();

        // oversized pattern length clamps to eight; leave bytes pending
        cfg_write(REG_PATTERN_LENGTH, 64'd12);
        send_byte(8'h80, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        // pause mid-text until nothing is outstanding, then change the
        // length: the pending window is discarded
        wait_idle();
        cfg_write(REG_PATTERN_LENGTH, 64'd2);
        send_byte(8'h80, 1'b0);
        wait_idle();
        // shorter replacement mid-text, used at the next comparison
        cfg_write(REG_REPLACEMENT_LENGTH, 64'd1);
        send_byte(8'h02, 1'b1);

        // --- random part: one register setting and idling mix per phase ---
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            wait_idle();
            idle_mode = idle_mode_t'(ph % 4);
            if (ph == 2 || ph == 3)
            begin
                // repeated byte: overlapping candidates, only leftmost counts
                fill_byte = byte_t'($urandom);
                word      = {8{fill_byte}};
            end
            else
            begin
                word = {$urandom, $urandom};
            end
            cfg_write(REG_PATTERN_BYTES, word);
            cfg_write(REG_PATTERN_LENGTH, DATA_W'(plen_set[ph]));
            cfg_write(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
            cfg_write(REG_REPLACEMENT_LENGTH, DATA_W'(rlen_set[ph]));
            stim_pattern = word;
            stim_plen    = (plen_set[ph] == 0) ? 1 :
                           (plen_set[ph] > MAX_PATTERN) ? MAX_PATTERN : plen_set[ph];

            if (ph == 4)
            begin
                // hold the receiver off while the sender keeps offering:
                // the job queue fills and the input stalls
                @(posedge clk);
                hold_left = HOLD_OFF;
                @(negedge clk);
            end

            goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < goal)
            begin
                send_text($urandom_range(1, 2 * stim_plen + 6));
            end
        end

        // drain, settle, verdict
        wait_idle();
        if (mismatch_count == 0)
        begin
            $display("[stream_pattern_replace_top] OK");
        end
        else
        begin
            $display("[stream_pattern_replace_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/spr_pkg.sv
hdl/spr_front.sv
hdl/spr_queue.sv
hdl/spr_back.sv
hdl/stream_pattern_replace_top.sv
bench/stream_pattern_replace_checker.sv
bench/stream_pattern_replace_top_tb.sv
